// File: src/jsd_pkg.sv
// Package for the job sequencing block: field widths, default slot count
// and the status record that each list cell hands to its neighbor.
// No dependencies.
package jsd_pkg;

  localparam int DL_W      = 7;
  localparam int PROFIT_W  = 20;
  localparam int SUM_W     = 26;
  localparam int CNT_W     = 7;
  localparam int SLOTS_DEF = 64;

  // Status of one list cell for the job on the input.
  typedef struct packed {
    logic le;   // occupied and deadline at most the new one
    logic bad;  // this position breaks the deadline rule
  } cell_stat_t;

endpackage

// File: src/jsd_in_if.sv
// Input channel of the job sequencing block: one job per beat.
// Depends on jsd_pkg for field widths.
interface jsd_in_if;
  logic                            valid;
  logic                            ready;
  logic [jsd_pkg::DL_W-1:0]        job_deadline;
  logic [jsd_pkg::PROFIT_W-1:0]    job_profit;
  logic                            batch_end;

  modport source (output valid, job_deadline, job_profit, batch_end, input ready);
  modport sink   (input valid, job_deadline, job_profit, batch_end, output ready);
endinterface

// File: src/jsd_out_if.sv
// Result channel of the job sequencing block: one result per beat.
// Depends on jsd_pkg for field widths.
interface jsd_out_if;
  logic                            valid;
  logic                            ready;
  logic                            accepted;
  logic [jsd_pkg::SUM_W-1:0]       total_profit;
  logic [jsd_pkg::CNT_W-1:0]       scheduled_count;
  logic                            batch_done;

  modport source (output valid, accepted, total_profit, scheduled_count, batch_done,
                  input ready);
  modport sink   (input valid, accepted, total_profit, scheduled_count, batch_done,
                  output ready);
endinterface

// File: src/jsd_cell.sv
// One cell of the sorted deadline list: holds one entry, checks it against
// the incoming job and shifts from its left neighbor. Depends on jsd_pkg.
module jsd_cell #(
  parameter int DW  = 7,
  parameter int IDX = 0
) (
  input  logic                 clk,
  input  logic                 commit,
  input  logic [DW-1:0]        len,
  input  logic [DW-1:0]        d,
  input  jsd_pkg::cell_stat_t  prev_stat,
  input  logic [DW-1:0]        prev_ent,
  output jsd_pkg::cell_stat_t  stat,
  output logic [DW-1:0]        ent
);
  import jsd_pkg::*;

  logic [DW-1:0] ent_r;
  logic          occ;
  logic          at_pos;
  logic          shift;

  assign occ    = len > DW'(IDX);
  assign stat.le = occ && (ent_r <= d);
  assign at_pos = prev_stat.le && !stat.le;
  assign shift  = occ && !stat.le;
  // A shifted entry moves to 1-based position IDX+2; the new job lands at IDX+1.
  assign stat.bad = (shift && ({1'b0, ent_r} < (DW+1)'(IDX + 2))) ||
                    (at_pos && ({1'b0, d} < (DW+1)'(IDX + 1)));
  assign ent = ent_r;

  always_ff @(posedge clk) begin
    if (commit && !stat.le) begin
      ent_r <= at_pos ? d : prev_ent;
    end
  end

endmodule

// File: src/job_sequencing_with_deadlines_unit.sv
// Greedy job sequencing with deadlines, built as a chain of list cells.
// A result is registered as its job is accepted and is offered in the next
// cycle. Throughput: one job per cycle unless the result channel stalls;
// every cell compares and shifts in the same cycle, and the feasibility check
// is a single OR over the cells' flags. Reset (rst_n low, synchronous) empties
// the list and clears the total and the valid flag; entries are not cleared.
module job_sequencing_with_deadlines_unit #(
  parameter int SLOTS = jsd_pkg::SLOTS_DEF
) (
  input logic      clk,
  input logic      rst_n,
  jsd_in_if.sink   in_ch,
  jsd_out_if.source out_ch
);
  import jsd_pkg::*;

  // Width that holds any deadline or count from 0 to SLOTS.
  localparam int DW = $clog2(SLOTS + 1);
  // Width wide enough for both the raw input deadline and SLOTS.
  localparam int IW = (DW > DL_W) ? DW : DL_W;

  logic [DW-1:0]        len_r;
  logic [SUM_W-1:0]     sum_r;
  logic                 out_valid_r;
  logic                 accepted_r;
  logic [SUM_W-1:0]     total_r;
  logic [CNT_W-1:0]     count_r;
  logic                 done_r;

  logic                 take;
  logic [IW-1:0]        d_ext;
  logic [DW-1:0]        d;
  logic                 ok;
  logic                 commit;
  logic [DW-1:0]        len_new;
  logic [SUM_W:0]       sum_wide;
  logic [SUM_W-1:0]     sum_new;
  logic [SLOTS-1:0]     bad_vec;

  cell_stat_t           stat [SLOTS];
  logic [DW-1:0]        ent  [SLOTS];

  // The output register frees as soon as its beat is taken, so a new job
  // can enter in the same cycle.
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign take        = in_ch.valid && in_ch.ready;

  // Deadlines beyond the slot count are clamped to it, so they fit in DW bits.
  assign d_ext = IW'(in_ch.job_deadline);
  assign d     = (d_ext > IW'(SLOTS)) ? DW'(SLOTS) : DW'(d_ext);

  // Each cell sees the new deadline, its left neighbor's status and entry.
  // Cell 0 behaves as if an always-smaller entry stood to its left.
  genvar gi;
  generate
    for (gi = 0; gi < SLOTS; gi++) begin : g_cell
      cell_stat_t    p_stat;
      logic [DW-1:0] p_ent;
      if (gi == 0) begin : g_head
        assign p_stat.le  = 1'b1;
        assign p_stat.bad = 1'b0;
        assign p_ent      = d;
      end else begin : g_body
        assign p_stat = stat[gi-1];
        assign p_ent  = ent[gi-1];
      end
      jsd_cell #(
        .DW  (DW),
        .IDX (gi)
      ) u_cell (
        .clk       (clk),
        .commit    (commit),
        .len       (len_r),
        .d         (d),
        .prev_stat (p_stat),
        .prev_ent  (p_ent),
        .stat      (stat[gi]),
        .ent       (ent[gi])
      );
      assign bad_vec[gi] = stat[gi].bad;
    end
  endgenerate

  // A job fits when it has a real deadline, the list has room and no cell
  // (including the one where the job would land) breaks its deadline.
  assign ok     = (d != '0) && (len_r < DW'(SLOTS)) && !(|bad_vec);
  assign commit = take && ok;

  assign len_new  = ok ? len_r + 1'b1 : len_r;
  assign sum_wide = {1'b0, sum_r} + (SUM_W+1)'(in_ch.job_profit);
  // The total saturates rather than wrapping when many slots are configured.
  assign sum_new  = !ok          ? sum_r :
                    sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        // A batch end reports the final values, then empties the schedule.
        len_r       <= in_ch.batch_end ? '0 : len_new;
        sum_r       <= in_ch.batch_end ? '0 : sum_new;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      accepted_r <= ok;
      total_r    <= sum_new;
      count_r    <= CNT_W'(len_new);
      done_r     <= in_ch.batch_end;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.accepted        = accepted_r;
  assign out_ch.total_profit    = total_r;
  assign out_ch.scheduled_count = count_r;
  assign out_ch.batch_done      = done_r;

endmodule
